>>> rtl/core/hbs_pkg.sv
// Package for the heightmap box smoothing block.
// Holds the controller state type, register map and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

  // Configuration register fields.
  localparam int unsigned MapWidthBits  = 11;
  localparam int unsigned MapHeightBits = 16;
  localparam int unsigned PaddrBits     = 3;
  localparam int unsigned PdataBits     = 32;

  localparam logic [MapWidthBits-1:0]  MapWidthReset  = 11'd1024;
  localparam logic [MapHeightBits-1:0] MapHeightReset = 16'd1024;

  // Register index, taken from the word address bit of paddr.
  localparam logic RegMapWidth  = 1'b0;
  localparam logic RegMapHeight = 1'b1;

  // Input item modes.
  localparam logic ModeSample = 1'b0;
  localparam logic ModeDrain  = 1'b1;

  // Neighbour count (at most 9) and quotient bits per divider cycle.
  localparam int unsigned CntBits       = 4;
  localparam int unsigned DivRadixBits  = 4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SAMP  = 7'b0000010,
    ST_SUM   = 7'b0000100,
    ST_RND   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_DRD   = 7'b1000000
  } hbs_state_e;

endpackage

`default_nettype wire

>>> rtl/core/heightmap_box_smoothing.sv
// Top level of the heightmap 3x3 box smoothing block: controller, window,
// sum and divider. Depends on hbs_pkg and hbs_ram (line store).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   mode_i, sample_i
// output    out        out_valid_o / out_stall_i smoothed_o, frame_end_o
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item is worked on at a time. A sample reads the line store, then writes
// back and shifts the window; each result it causes then passes the sum,
// rounding and divider states in that order, the divider giving four
// quotient bits a cycle. A drain item reads its one to three columns from the
// line store one a cycle, then rounds and divides the same way.
// Reset clears the counters and the controller; the line store has no
// clearing pass. Results go to an output register; a further result waits
// while that transaction is stalled, and the input is stalled meanwhile.
module heightmap_box_smoothing
  import hbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input channel.
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   mode_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  // Output channel.
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [SAMPLE_BITS-1:0] smoothed_o,
  output logic                        frame_end_o,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PaddrBits-1:0]   paddr,
  input  wire logic [PdataBits-1:0]   pwdata,
  output logic      [PdataBits-1:0]   prdata,
  output logic                        pready
);

  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH);
  localparam int unsigned W_W     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + 4;
  localparam int unsigned DIV_CYC = (SUM_W + DivRadixBits - 1) / DivRadixBits;
  localparam int unsigned DIV_W   = DIV_CYC * DivRadixBits;
  localparam int unsigned STEP_W  = $clog2(DIV_CYC);

  hbs_state_e state_q, state_d;

  logic [MapWidthBits-1:0]  map_width_q;
  logic [MapHeightBits-1:0] map_height_q;
  logic [MapHeightBits-1:0] row_q;
  logic [ADDR_W-1:0]        col_cnt_q;
  logic [ADDR_W-1:0]        drain_q;

  // Per-item working registers.
  logic                     is_drain_q;
  logic                     last_q;
  logic                     skip_top_q;
  logic [1:0]               pend_q;
  logic [1:0]               c0a_q, c0b_q;
  logic [ADDR_W-1:0]        col_q, hi_q;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [SAMPLE_BITS-1:0]   win_q [3][3];
  logic [SUM_W-1:0]         sum_q;
  logic [CntBits-1:0]       cnt_q;
  logic [DIV_W-1:0]         div_q;
  logic [CntBits-1:0]       rem_q;
  logic [STEP_W-1:0]        step_q;
  logic [SAMPLE_BITS-1:0]   smoothed_q;
  logic                     frame_end_q;
  logic                     out_valid_q;

  // Effective map size.
  logic [31:0]              mw_ext;
  logic [W_W-1:0]           eff_w;
  logic [MapHeightBits-1:0] eff_h;

  always_comb begin
    mw_ext = 32'(map_width_q);
    if (mw_ext == 32'd0) begin
      eff_w = W_W'(1);
    end else if (mw_ext > 32'(MAX_WIDTH)) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(mw_ext);
    end
    eff_h = (map_height_q == '0) ? MapHeightBits'(1) : map_height_q;
  end

  // Column of an incoming sample and columns of a drain item.
  logic [ADDR_W-1:0] c_smp, k_drn, lo_drn, hi_drn;
  logic              smp_row_end, drn_last;

  always_comb begin
    c_smp       = (W_W'(col_cnt_q) >= eff_w) ? '0 : col_cnt_q;
    smp_row_end = (W_W'(c_smp) + W_W'(1)) >= eff_w;
    k_drn       = (W_W'(drain_q) >= eff_w) ? ADDR_W'(eff_w - W_W'(1)) : drain_q;
    lo_drn      = (k_drn != '0) ? k_drn - ADDR_W'(1) : k_drn;
    hi_drn      = ((W_W'(k_drn) + W_W'(1)) < eff_w) ? k_drn + ADDR_W'(1) : k_drn;
    drn_last    = W_W'(k_drn) == (eff_w - W_W'(1));
  end

  logic in_acc, res_last, res_load, cfg_wr;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign res_last = (state_q == ST_DIV) && (step_q == STEP_W'(DIV_CYC - 1));
  // A finished result moves into the output register once that register is free.
  assign res_load = (res_last || (state_q == ST_OUT)) && (!out_valid_q || !out_stall_i);
  assign cfg_wr   = psel && penable && pwrite;

  logic smp_live, drn_live;
  assign smp_live = (mode_i == ModeSample) && (row_q < eff_h);
  assign drn_live = (mode_i == ModeDrain) && (row_q >= eff_h);

  // Line store: each entry holds {row above previous, previous row} of a column.
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [2*SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]     rd_top, rd_mid;

  assign ram_we = (state_q == ST_SAMP);
  assign rd_top = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_mid = ram_rdata[SAMPLE_BITS-1:0];

  always_comb begin
    case (state_q)
      ST_IDLE: ram_raddr = (mode_i == ModeDrain) ? lo_drn : c_smp;
      ST_DRD:  ram_raddr = col_q + ADDR_W'(1);
      default: ram_raddr = col_q;
    endcase
  end

  hbs_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({rd_mid, sample_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Masked window sum for the result that is up next.
  logic [1:0]         c0_sel;
  logic [SUM_W-1:0]   win_sum;
  logic [CntBits-1:0] win_cnt;

  always_comb begin
    c0_sel  = pend_q[0] ? c0a_q : c0b_q;
    win_sum = '0;
    win_cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if ((r >= (skip_top_q ? 1 : 0)) && (k >= int'(c0_sel))) begin
          win_sum = win_sum + SUM_W'(win_q[r][k]);
          win_cnt = win_cnt + CntBits'(1);
        end
      end
    end
  end

  // Drain accumulation of one line store column.
  logic [SUM_W-1:0]   drn_sum;
  logic [CntBits-1:0] drn_cnt;

  always_comb begin
    drn_sum = sum_q + SUM_W'(rd_mid);
    drn_cnt = cnt_q + CntBits'(1);
    if (!skip_top_q) begin
      drn_sum = drn_sum + SUM_W'(rd_top);
      drn_cnt = drn_cnt + CntBits'(1);
    end
  end

  // Restoring divider by the neighbour count, several quotient bits a cycle.
  logic [DIV_W-1:0]        div_d;
  logic [CntBits-1:0]      rem_d;
  logic [DivRadixBits-1:0] qbits;

  always_comb begin
    logic [CntBits:0] part;
    rem_d = rem_q;
    qbits = '0;
    for (int i = 0; i < int'(DivRadixBits); i++) begin
      part = {rem_d, div_q[DIV_W-1-i]};
      if (part >= {1'b0, cnt_q}) begin
        part = part - {1'b0, cnt_q};
        qbits[DivRadixBits-1-i] = 1'b1;
      end
      rem_d = part[CntBits-1:0];
    end
    div_d = {div_q[DIV_W-DivRadixBits-1:0], qbits};
  end

  // Controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && smp_live) begin
          state_d = ST_SAMP;
        end else if (in_acc && drn_live) begin
          state_d = ST_DRD;
        end
      end
      ST_SAMP: state_d = (pend_q != 2'b00) ? ST_SUM : ST_IDLE;
      ST_SUM:  state_d = ST_RND;
      ST_RND:  state_d = ST_DIV;
      ST_DIV: begin
        if (res_load) begin
          state_d = (pend_q[0] && pend_q[1]) ? ST_SUM : ST_IDLE;
        end else if (res_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_load) begin
          state_d = (pend_q[0] && pend_q[1]) ? ST_SUM : ST_IDLE;
        end
      end
      ST_DRD:  state_d = (col_q == hi_q) ? ST_RND : ST_DRD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      map_width_q  <= MapWidthReset;
      map_height_q <= MapHeightReset;
      row_q        <= '0;
      col_cnt_q    <= '0;
      drain_q      <= '0;
      pend_q       <= 2'b00;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == RegMapWidth) begin
          map_width_q <= pwdata[MapWidthBits-1:0];
        end else begin
          map_height_q <= pwdata[MapHeightBits-1:0];
        end
        row_q     <= '0;
        col_cnt_q <= '0;
        drain_q   <= '0;
      end else if (in_acc && smp_live) begin
        if (smp_row_end) begin
          col_cnt_q <= '0;
          row_q     <= row_q + MapHeightBits'(1);
          drain_q   <= '0;
        end else begin
          col_cnt_q <= c_smp + ADDR_W'(1);
        end
      end else if (in_acc && drn_live) begin
        if (drn_last) begin
          row_q     <= '0;
          col_cnt_q <= '0;
          drain_q   <= '0;
        end else begin
          drain_q <= k_drn + ADDR_W'(1);
        end
      end
      if (in_acc && smp_live) begin
        pend_q[0] <= (row_q != '0) && (c_smp != '0);
        pend_q[1] <= (row_q != '0) && smp_row_end;
      end else if (in_acc && drn_live) begin
        pend_q <= 2'b00;
      end else if (res_load) begin
        if (pend_q[0]) begin
          pend_q[0] <= 1'b0;
        end else begin
          pend_q[1] <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_drain_q <= (mode_i == ModeDrain);
      sample_q   <= sample_i;
      if (mode_i == ModeDrain) begin
        col_q      <= lo_drn;
        hi_q       <= hi_drn;
        last_q     <= drn_last;
        skip_top_q <= (eff_h < MapHeightBits'(2));
        sum_q      <= '0;
        cnt_q      <= '0;
      end else begin
        col_q      <= c_smp;
        skip_top_q <= (row_q < MapHeightBits'(2));
        c0a_q      <= (c_smp >= ADDR_W'(2)) ? 2'd0 : 2'd1;
        c0b_q      <= (c_smp != '0) ? 2'd1 : 2'd2;
      end
    end
    case (state_q)
      ST_SAMP: begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= rd_top;
        win_q[1][2] <= rd_mid;
        win_q[2][2] <= sample_q;
      end
      ST_SUM: begin
        sum_q <= win_sum;
        cnt_q <= win_cnt;
      end
      ST_RND: begin
        // Round to nearest, ties upward.
        div_q  <= DIV_W'(sum_q) + DIV_W'(cnt_q >> 1);
        rem_q  <= '0;
        step_q <= '0;
      end
      ST_DIV: begin
        div_q  <= div_d;
        rem_q  <= rem_d;
        step_q <= step_q + STEP_W'(1);
      end
      ST_DRD: begin
        sum_q <= drn_sum;
        cnt_q <= drn_cnt;
        col_q <= col_q + ADDR_W'(1);
      end
      default: begin
      end
    endcase
    if (res_load) begin
      smoothed_q  <= (state_q == ST_OUT) ? div_q[SAMPLE_BITS-1:0] : div_d[SAMPLE_BITS-1:0];
      frame_end_q <= is_drain_q && last_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign frame_end_o = frame_end_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMapHeight) ? PdataBits'(map_height_q)
                                             : PdataBits'(map_width_q);

endmodule

`default_nettype wire

>>> rtl/core/hbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line store of the box smoothing block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> verif/tb_heightmap_box_smoothing.sv
// Self-checking testbench for heightmap_box_smoothing: raster frames of height
// samples and drain transactions, checked against a 3x3 neighbourhood mean predictor.
// Depends on hbs_pkg and the heightmap_box_smoothing RTL.
`timescale 1ns / 1ps

module tb_heightmap_box_smoothing
  import hbs_pkg::*;
;

  localparam int unsigned SampleBits   = 16;
  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;

  typedef struct packed {
    logic                  mode;
    logic [SampleBits-1:0] sample;
  } height_item_t;

  typedef struct packed {
    logic [SampleBits-1:0] mean;
    logic                  frame_end;
  } smoothed_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   mode_i      = 1'b0;
  logic [SampleBits-1:0]  sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SampleBits-1:0]  smoothed_o;
  logic                   frame_end_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [PaddrBits-1:0]   paddr       = '0;
  logic [PdataBits-1:0]   pwdata      = '0;
  logic [PdataBits-1:0]   prdata;
  logic                   pready;

  height_item_t height_items[$];
  smoothed_t    pending_means[$];

  int unsigned items_pushed  = 0;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_armed    = 1'b0;
  bit          hold_used     = 1'b0;
  bit          in_taken      = 1'b0;

  // Predictor state.
  logic [SampleBits-1:0]    line_mem [2][MaxWidth];
  logic [SampleBits-1:0]    win [3][3];
  logic [MapWidthBits-1:0]  map_w_cfg;
  logic [MapHeightBits-1:0] map_h_cfg;
  int unsigned              row_cnt, col_cnt, drain_cnt;

  heightmap_box_smoothing i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .smoothed_o  (smoothed_o),
    .frame_end_o (frame_end_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [SampleBits-1:0] rounded_mean(int unsigned sum, int unsigned n);
    return SampleBits'((sum + n / 2) / n);
  endfunction

  function automatic logic [SampleBits-1:0] win_mean(int unsigned r0, int unsigned c0);
    int unsigned sum, n;
    sum = 0;
    n   = 0;
    for (int unsigned r = r0; r < 3; r++) begin
      for (int unsigned c = c0; c < 3; c++) begin
        sum += win[r][c];
        n++;
      end
    end
    return rounded_mean(sum, n);
  endfunction

  function automatic void expect_mean(logic [SampleBits-1:0] mean, logic fe);
    pending_means.insert(pending_means.size(), smoothed_t'{mean, fe});
  endfunction

  function automatic void box_filter_predict(logic mode, logic [SampleBits-1:0] s);
    int unsigned w, h, c, k, r0, lo, hi, sum, n;
    logic [SampleBits-1:0] top, mid;
    bit last;
    w = (map_w_cfg == 0) ? 1 : ((map_w_cfg > MaxWidth) ? MaxWidth : map_w_cfg);
    h = (map_h_cfg == 0) ? 1 : map_h_cfg;
    if (mode == ModeSample) begin
      // Samples are dropped once the frame is complete and draining.
      if (row_cnt >= h) return;
      c = (col_cnt >= w) ? 0 : col_cnt;
      top = line_mem[0][c];
      mid = line_mem[1][c];
      line_mem[0][c] = mid;
      line_mem[1][c] = s;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = s;
      if (row_cnt >= 1) begin
        r0 = (row_cnt >= 2) ? 0 : 1;
        if (c >= 1) expect_mean(win_mean(r0, (c >= 2) ? 0 : 1), 1'b0);
        // The last column of the row above closes with this sample.
        if (c == w - 1) expect_mean(win_mean(r0, (c >= 1) ? 1 : 2), 1'b0);
      end
      if (c + 1 >= w) begin
        col_cnt   = 0;
        row_cnt   = row_cnt + 1;
        drain_cnt = 0;
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      if (row_cnt < h) return;
      k   = (drain_cnt >= w) ? w - 1 : drain_cnt;
      r0  = (h >= 2) ? 0 : 1;
      lo  = (k >= 1) ? k - 1 : k;
      hi  = (k + 1 < w) ? k + 1 : k;
      sum = 0;
      n   = 0;
      for (int unsigned r = r0; r < 2; r++) begin
        for (int unsigned x = lo; x <= hi; x++) begin
          sum += line_mem[r][x];
          n++;
        end
      end
      last = (k == w - 1);
      expect_mean(rounded_mean(sum, n), last);
      if (last) begin
        row_cnt   = 0;
        col_cnt   = 0;
        drain_cnt = 0;
      end else begin
        drain_cnt = k + 1;
      end
    end
  endfunction

  function automatic logic [SampleBits-1:0] rand_height();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SampleBits'($urandom());
    endcase
  endfunction

  function automatic void push_item(logic mode, logic [SampleBits-1:0] s);
    height_items.insert(height_items.size(), height_item_t'{mode, s});
    items_pushed++;
  endfunction

  task automatic wait_drained();
    while (height_items.size() != 0 || in_valid_i || pending_means.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [PdataBits-1:0] wdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMapWidth) map_w_cfg = wdata[MapWidthBits-1:0];
    else                    map_h_cfg = wdata[MapHeightBits-1:0];
    // Any register write restarts the frame.
    row_cnt   = 0;
    col_cnt   = 0;
    drain_cnt = 0;
  endtask

  // Upper data bits carry junk; only the register's own bits may count.
  task automatic set_map(int unsigned w_val, int unsigned h_val);
    reg_write(RegMapWidth, ($urandom() & ~32'h7FF) | w_val);
    reg_write(RegMapHeight, ($urandom() & ~32'hFFFF) | h_val);
  endtask

  task automatic push_frame(int unsigned w_eff, int unsigned h_eff, int unsigned noise_pct,
                            bit cut);
    int unsigned n_samp, i;
    n_samp = w_eff * h_eff;
    if (cut && $urandom_range(1, w_eff * 3 + 2) < n_samp) begin
      n_samp = $urandom_range(1, w_eff * 3 + 2);
    end
    for (i = 0; i < n_samp; i++) begin
      if ($urandom_range(99) < noise_pct) push_item(ModeDrain, rand_height());
      push_item(ModeSample, rand_height());
    end
    if (!cut) begin
      for (i = 0; i < w_eff; i++) begin
        if ($urandom_range(99) < noise_pct) push_item(ModeSample, rand_height());
        push_item(ModeDrain, rand_height());
      end
    end
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned w_val, h_val, w_eff, h_eff, start;
    bit cut;
    start = items_pushed;
    while (items_pushed - start < target) begin
      case ($urandom_range(19))
        0: w_val = 0;
        1: w_val = 1;
        2: w_val = $urandom_range(9, 40);
        default: w_val = $urandom_range(2, 6);
      endcase
      case ($urandom_range(19))
        0: h_val = 0;
        1: h_val = 1;
        2: h_val = 65535;
        3: h_val = $urandom_range(6, 12);
        default: h_val = $urandom_range(2, 5);
      endcase
      w_eff = (w_val == 0) ? 1 : w_val;
      h_eff = (h_val == 0) ? 1 : h_val;
      cut   = (h_val == 65535) || ($urandom_range(99) < 15);
      set_map(w_val, h_val);
      push_frame(w_eff, h_eff, $urandom_range(1) ? 8 : 0, cut);
      // Back-to-back frames check that the counters wrap on their own.
      if (!cut && $urandom_range(2) == 0) push_frame(w_eff, h_eff, 0, 1'b0);
      wait_drained();
    end
  endtask

  // Sender: a new transaction is offered only once the previous one is taken.
  always @(negedge clk_i) begin
    height_item_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (height_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = height_items.pop_front();
        in_valid_i <= 1'b1;
        mode_i     <= nxt.mode;
        sample_i   <= nxt.sample;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_armed && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    smoothed_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) box_filter_predict(mode_i, sample_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with none expected: smoothed=%h frame_end=%b",
                     $time, smoothed_o, frame_end_o);
          end
        end else begin
          want = pending_means.pop_front();
          if (smoothed_o !== want.mean || frame_end_o !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected smoothed=%h frame_end=%b,",
                       $time, want.mean, want.frame_end,
                       " got smoothed=%h frame_end=%b", smoothed_o, frame_end_o);
            end
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_heightmap_box_smoothing NOT OK");
    $finish;
  end

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    map_w_cfg = MapWidthReset;
    map_h_cfg = MapHeightReset;
    row_cnt   = 0;
    col_cnt   = 0;
    drain_cnt = 0;
    send_idle_pct = 38;
    recv_idle_pct = 79;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: a sample, then a drain that comes before the frame is complete.
    push_item(ModeSample, 16'hFFFF);
    push_item(ModeDrain, 16'h1234);
    wait_drained();

    // A 2x2 map, with a sample during the drain and an early drain after it.
    set_map(2, 2);
    push_item(ModeSample, 16'hFFFF);
    push_item(ModeSample, 16'h0000);
    push_item(ModeSample, 16'h0001);
    push_item(ModeSample, 16'hFFFF);
    push_item(ModeSample, 16'h5555);
    push_item(ModeDrain, 16'h0000);
    push_item(ModeDrain, 16'hFFFF);
    push_item(ModeDrain, 16'h0000);
    wait_drained();

    // Zero width and height act as a single sample map.
    set_map(0, 0);
    push_item(ModeSample, 16'hAAAA);
    push_item(ModeDrain, 16'h0000);
    wait_drained();

    // Full-scale samples everywhere: the mean must not overflow.
    set_map(3, 3);
    repeat (9) push_item(ModeSample, 16'hFFFF);
    repeat (3) push_item(ModeDrain, 16'h0000);
    wait_drained();

    random_phase(400);

    send_idle_pct = 79;
    recv_idle_pct = 38;
    random_phase(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while the sender keeps streaming.
    set_map(4, 8);
    hold_armed = 1'b1;
    push_frame(4, 8, 0, 1'b0);
    wait_drained();
    random_phase(100);

    // Oversized width saturates: the second row starts after 1024 samples.
    set_map(2047, 65535);
    repeat (MaxWidth + 4) push_item(ModeSample, rand_height());
    wait_drained();

    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("tb_heightmap_box_smoothing OK");
    end else begin
      $display("tb_heightmap_box_smoothing NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hbs_pkg.sv
rtl/core/hbs_ram.sv
rtl/core/heightmap_box_smoothing.sv
verif/tb_heightmap_box_smoothing.sv
